// File: rtl/pte_pkg.sv
// Package for the prime table engine: sizes, query codes, sequencer states
// and the request struct for the shared arithmetic unit. No dependencies.
package pte_pkg;

  localparam int TABLE_DEPTH = 8192;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int COUNT_STEP  = 10;
  localparam logic [31:0] FIRST_PRIME  = 32'd2;
  localparam logic [31:0] SECOND_PRIME = 32'd3;

  typedef enum logic [1:0] {
    FN_NTH   = 2'd0,
    FN_TEST  = 2'd1,
    FN_INDEX = 2'd2,
    FN_COUNT = 2'd3
  } func_t;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_REM = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROOT_MUL,
    S_ROOT_WAIT,
    S_ENSURE,
    S_RD,
    S_EVAL,
    S_Q_REMW,
    S_CNT_RD,
    S_CNT_EV,
    S_G_INIT,
    S_G_RD,
    S_G_MUL,
    S_G_MULW,
    S_G_REMW,
    S_G_WR
  } state_t;

endpackage

// File: rtl/pte_ram.sv
// Generic simple dual-port RAM, registered read with read enable.
// No dependencies.
module pte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/pte_alu.sv
// Shared arithmetic unit: registered 32x32 multiply, or 32-step restoring
// remainder (one bit per cycle). Depends on pte_pkg.
module pte_alu (
  input  logic              clk,
  input  logic              rst,
  input  pte_pkg::alu_req_t req,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  output logic              done,
  output logic [63:0]       res
);
  import pte_pkg::*;

  logic        active;
  logic [5:0]  cnt;
  logic [32:0] r;
  logic [31:0] dvd;
  logic [31:0] dvs;
  logic [32:0] r_shift;
  logic [32:0] r_new;

  always_comb begin
    r_shift = {r[31:0], dvd[31]};
    if (r_shift >= {1'b0, dvs}) begin
      r_new = r_shift - {1'b0, dvs};
    end else begin
      r_new = r_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        if (req.op == OP_MUL) begin
          res  <= a * b;
          done <= 1'b1;
        end else begin
          r      <= '0;
          dvd    <= a;
          dvs    <= b;
          cnt    <= 6'd32;
          active <= 1'b1;
        end
      end else if (active) begin
        r   <= r_new;
        dvd <= {dvd[30:0], 1'b0};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          active <= 1'b0;
          done   <= 1'b1;
          res    <= {32'd0, r_new[31:0]};
        end
      end
    end
  end

endmodule

// File: rtl/prime_table_engine_unit.sv
// Prime table engine: query sequencer, prime table RAM and shared ALU.
// Latency is data dependent: growing the table by one prime costs at most
// one division per stored odd prime up to its root, per candidate. A
// primality query first finds the integer root of its value. One query at
// a time; results cannot be stalled. Synchronous reset restores the table
// to {2, 3}.
module prime_table_engine_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  func,
  input  logic [31:0] query_value,
  output logic        busy,
  output logic        done,
  output logic [31:0] result_value,
  output logic        is_prime,
  output logic        found,
  output logic        table_error
);
  import pte_pkg::*;

  state_t            state, state_next;
  func_t             func_r;
  logic [31:0]       val_r;
  logic [31:0]       idx;
  logic [15:0]       root;
  logic [3:0]        bit_r;
  logic [15:0]       trial;
  logic [CNT_W-1:0]  count;
  logic [31:0]       last_prime;
  logic [31:0]       cand;
  logic [CNT_W-1:0]  k;
  logic [CNT_W-1:0]  c;
  logic [31:0]       p;

  alu_req_t          alu_req;
  logic [31:0]       alu_a, alu_b;
  logic              alu_done;
  logic [63:0]       alu_res;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [IDX_W-1:0]  raddr_q;
  logic [31:0]       ram_q;
  logic [31:0]       rdata;
  logic [CNT_W-1:0]  c_dec;

  assign trial = root | (16'd1 << bit_r);
  assign c_dec = c - 1'b1;
  assign busy  = (state != S_IDLE);

  // entries 0 and 1 are fixed primes, never held in the RAM
  assign rdata = (raddr_q == '0) ? FIRST_PRIME :
                 (raddr_q == IDX_W'(1)) ? SECOND_PRIME : ram_q;

  pte_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[IDX_W-1:0]),
    .wdata (cand),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  pte_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .req  (alu_req),
    .a    (alu_a),
    .b    (alu_b),
    .done (alu_done),
    .res  (alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    alu_req.start = 1'b0;
    alu_req.op    = OP_MUL;
    alu_a         = {16'd0, trial};
    alu_b         = {16'd0, trial};
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = idx[IDX_W-1:0];
    unique case (state)
      S_IDLE: begin
        if (start) begin
          priority if (func_t'(func) == FN_COUNT && query_value < 32'd2) begin
            state_next = S_IDLE;
          end else if (func_t'(func) == FN_TEST) begin
            state_next = S_ROOT_MUL;
          end else begin
            state_next = S_ENSURE;
          end
        end
      end
      S_ROOT_MUL: begin
        alu_req.start = 1'b1;
        state_next    = S_ROOT_WAIT;
      end
      S_ROOT_WAIT: begin
        if (alu_done) begin
          state_next = (bit_r == 4'd0) ? S_ENSURE : S_ROOT_MUL;
        end
      end
      S_ENSURE: begin
        priority if (idx >= 32'(TABLE_DEPTH)) begin
          state_next = S_IDLE;
        end else if (idx >= 32'(count)) begin
          state_next = S_G_INIT;
        end else begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        ram_re     = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        unique case (func_r)
          FN_NTH:   state_next = S_IDLE;
          FN_TEST: begin
            if (rdata > {16'd0, root}) begin
              state_next = S_IDLE;
            end else begin
              alu_req.start = 1'b1;
              alu_req.op    = OP_REM;
              alu_a         = val_r;
              alu_b         = rdata;
              state_next    = S_Q_REMW;
            end
          end
          FN_INDEX: state_next = (rdata >= val_r) ? S_IDLE : S_ENSURE;
          FN_COUNT: state_next = (rdata >= val_r) ? S_CNT_RD : S_ENSURE;
          default:  state_next = S_IDLE;
        endcase
      end
      S_Q_REMW: begin
        if (alu_done) begin
          state_next = (alu_res == 64'd0) ? S_IDLE : S_ENSURE;
        end
      end
      S_CNT_RD: begin
        ram_re     = 1'b1;
        ram_raddr  = c_dec[IDX_W-1:0];
        state_next = S_CNT_EV;
      end
      S_CNT_EV: begin
        state_next = (rdata > val_r) ? S_CNT_RD : S_IDLE;
      end
      S_G_INIT: state_next = S_G_RD;
      S_G_RD: begin
        if (k >= count) begin
          state_next = S_G_WR;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = k[IDX_W-1:0];
          state_next = S_G_MUL;
        end
      end
      S_G_MUL: begin
        alu_req.start = 1'b1;
        alu_a         = rdata;
        alu_b         = rdata;
        state_next    = S_G_MULW;
      end
      S_G_MULW: begin
        if (alu_done) begin
          if (alu_res > {32'd0, cand}) begin
            state_next = S_G_WR;
          end else begin
            alu_req.start = 1'b1;
            alu_req.op    = OP_REM;
            alu_a         = cand;
            alu_b         = p;
            state_next    = S_G_REMW;
          end
        end
      end
      S_G_REMW: begin
        if (alu_done) begin
          state_next = S_G_RD;
        end
      end
      S_G_WR: begin
        ram_we     = 1'b1;
        state_next = S_ENSURE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= CNT_W'(2);
      last_prime <= SECOND_PRIME;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ram_re) begin
        raddr_q <= ram_raddr;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            func_r <= func_t'(func);
            val_r  <= query_value;
            root   <= '0;
            bit_r  <= 4'd15;
            unique case (func_t'(func))
              FN_NTH:   idx <= query_value;
              FN_COUNT: idx <= 32'(COUNT_STEP);
              default:  idx <= '0;
            endcase
            if (func_t'(func) == FN_COUNT && query_value < 32'd2) begin
              done         <= 1'b1;
              result_value <= '0;
              is_prime     <= 1'b0;
              found        <= 1'b0;
              table_error  <= 1'b0;
            end
          end
        end
        S_ROOT_WAIT: begin
          if (alu_done) begin
            if (alu_res <= {32'd0, val_r}) begin
              root <= trial;
            end
            bit_r <= bit_r - 4'd1;
          end
        end
        S_ENSURE: begin
          if (idx >= 32'(TABLE_DEPTH)) begin
            done         <= 1'b1;
            result_value <= '0;
            is_prime     <= 1'b0;
            found        <= 1'b0;
            table_error  <= 1'b1;
          end
        end
        S_EVAL: begin
          unique case (func_r)
            FN_NTH: begin
              done         <= 1'b1;
              result_value <= rdata;
              is_prime     <= 1'b0;
              found        <= 1'b0;
              table_error  <= 1'b0;
            end
            FN_TEST: begin
              if (rdata > {16'd0, root}) begin
                done         <= 1'b1;
                result_value <= '0;
                is_prime     <= (val_r > 32'd1);
                found        <= 1'b0;
                table_error  <= 1'b0;
              end
            end
            FN_INDEX: begin
              if (rdata >= val_r) begin
                done         <= 1'b1;
                result_value <= (rdata == val_r) ? idx : '0;
                is_prime     <= 1'b0;
                found        <= (rdata == val_r);
                table_error  <= 1'b0;
              end else begin
                idx <= idx + 32'd1;
              end
            end
            FN_COUNT: begin
              if (rdata >= val_r) begin
                c <= idx[CNT_W-1:0] + 1'b1;
              end else begin
                idx <= idx + 32'(COUNT_STEP);
              end
            end
            default: ;
          endcase
        end
        S_Q_REMW: begin
          if (alu_done) begin
            if (alu_res == 64'd0) begin
              done         <= 1'b1;
              result_value <= '0;
              is_prime     <= 1'b0;
              found        <= 1'b0;
              table_error  <= 1'b0;
            end else begin
              idx <= idx + 32'd1;
            end
          end
        end
        S_CNT_EV: begin
          if (rdata > val_r) begin
            c <= c_dec;
          end else begin
            done         <= 1'b1;
            result_value <= 32'(c);
            is_prime     <= 1'b0;
            found        <= 1'b0;
            table_error  <= 1'b0;
          end
        end
        S_G_INIT: begin
          cand <= last_prime + 32'd2;
          k    <= CNT_W'(1);
        end
        S_G_MUL: p <= rdata;
        S_G_REMW: begin
          if (alu_done) begin
            if (alu_res == 64'd0) begin
              cand <= cand + 32'd2;
              k    <= CNT_W'(1);
            end else begin
              k <= k + 1'b1;
            end
          end
        end
        S_G_WR: begin
          count      <= count + 1'b1;
          last_prime <= cand;
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (done && table_error) |-> (result_value == 32'd0 && !is_prime && !found))
    else $error("error result carries data");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !(func_t'(func) == FN_COUNT && query_value < 32'd2)) |=> busy)
    else $error("accepted request did not start");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= 32'(TABLE_DEPTH))
    else $error("prime count overflow");
`endif

endmodule
